// File: rtl/tve_pkg.sv
// Shared types and constants for the track velocity estimator.
`default_nettype none
package tve_pkg;
    localparam int XW = 32;
    localparam int YAWW = 16;
    localparam int TW = 40;
    localparam int TRKW = 4;
    localparam int ALPHAW = 9;
    localparam int INTW = 24;
    localparam logic [YAWW-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [1:0] ADDR_ALPHA = 2'd0;
    localparam logic [1:0] ADDR_INTERVAL = 2'd1;
    localparam logic [ALPHAW-1:0] ALPHA_RESET = 9'd128;
    localparam logic [INTW-1:0] INTERVAL_RESET = 24'd100000;

    typedef struct packed {
        logic              mode;
        logic [TRKW-1:0]   track;
        logic [XW-1:0]     pos_x;
        logic [XW-1:0]     pos_y;
        logic [YAWW-1:0]   yaw;
        logic [TW-1:0]     sample_time;
    } item_t;
endpackage
`default_nettype wire

// File: rtl/tve_queue.sv
// Two-entry queue between the front and the back of the estimator.
`default_nettype none
module tve_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire tve_pkg::item_t wr_data,
    output logic               full,
    output logic               not_empty,
    output tve_pkg::item_t     rd_data,
    input  wire logic          rd_en
);
    import tve_pkg::*;
    item_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];
    assign full = cnt_reg[1];
    assign not_empty = cnt_reg != 2'd0;
endmodule
`default_nettype wire

// File: rtl/tve_divider.sv
// Sequential signed divider, one quotient bit per cycle, truncating and saturating.
`default_nettype none
module tve_divider
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic signed [57:0] dividend,
    input  wire logic [39:0]       divisor,
    output logic                   done,
    output logic signed [31:0]     quotient
);
    logic [57:0] rem_reg, quo_reg;
    logic [39:0] den_reg;
    logic neg_reg, busy_reg, done_reg;
    logic [5:0] cnt_reg;
    logic [58:0] trial;
    logic [57:0] remsh;
    logic [58:0] sq;

    assign remsh = {rem_reg[56:0], quo_reg[57]};
    assign trial = {1'b0, remsh} - {19'd0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd57)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[57];
            quo_reg <= dividend[57] ? -dividend : dividend;
            rem_reg <= 58'd0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[58])
                rem_reg <= trial[57:0];
            else
                rem_reg <= remsh;
            quo_reg <= {quo_reg[56:0], ~trial[58]};
        end
    end

    always_comb
    begin
        sq = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
        if (!neg_reg && quo_reg > 58'h7FFFFFFF)
            quotient = 32'sh7FFFFFFF;
        else if (neg_reg && quo_reg > 58'h80000000)
            quotient = 32'sh80000000;
        else
            quotient = sq[31:0];
    end
    assign done = done_reg;
endmodule
`default_nettype wire

// File: rtl/tve_back.sv
// Back end: per-track history, velocity difference, division and smoothing.
`default_nettype none
module tve_back
#(
    parameter int TRACKS = 16,
    parameter int HISTORY_DEPTH = 5,
    parameter int STEP = 3
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire tve_pkg::item_t       q_data,
    output logic                      q_pop,
    input  wire logic [8:0]           alpha_q8,
    input  wire logic [23:0]          min_interval,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [3:0]                out_track,
    output logic signed [31:0]        out_x,
    output logic signed [31:0]        out_y,
    output logic signed [15:0]        heading,
    output logic signed [31:0]        vel_x,
    output logic signed [31:0]        vel_y,
    output logic signed [31:0]        yaw_rate,
    output logic                      vel_valid
);
    import tve_pkg::*;
    localparam int TIW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int MD = TRACKS * HISTORY_DEPTH;
    localparam int MAW = $clog2(MD);

    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CALC = 3'd2, S_DIV = 3'd3,
        S_EMA = 3'd4, S_OUT = 3'd5;

    logic [XW-1:0]   hx_mem [MD];
    logic [XW-1:0]   hy_mem [MD];
    logic [YAWW-1:0] ha_mem [MD];
    logic [TW-1:0]   hs_mem [MD];
    logic [XW-1:0] evx_mem [TRACKS];
    logic [XW-1:0] evy_mem [TRACKS];
    logic [XW-1:0] evw_mem [TRACKS];
    logic [TW-1:0] lst_mem [TRACKS];
    logic [CW-1:0] cnt_reg [TRACKS];
    logic [HW-1:0] head_reg [TRACKS];
    logic [TRACKS-1:0] ev_reg, seen_reg;
    logic [TW-1:0] lft_reg;

    logic [2:0] st_reg;
    item_t it_reg;
    logic [TIW-1:0] t;
    logic [MAW-1:0] ni_reg, ri_reg;
    logic [XW-1:0] nx_reg, rx_reg, ny_reg, ry_reg;
    logic [YAWW-1:0] na_reg, ra_reg;
    logic [TW-1:0] ns_reg, rs_reg;
    logic [1:0] dsel_reg;
    logic signed [31:0] ix_reg, iy_reg, iw_reg;
    logic comp_reg;
    logic [1:0] esel_reg;
    logic signed [31:0] ax_reg, ay_reg, aw_reg;
    logic signed [31:0] prod_prev;
    logic [8:0] a_eff;
    logic div_start, div_done;
    logic signed [57:0] div_num;
    logic signed [31:0] div_q;
    logic [HW-1:0] nidx, ridx;
    logic [TW-1:0] gap_reg;
    logic signed [32:0] dx33;
    logic signed [15:0] dw16;

    assign t = it_reg.track[TIW-1:0];

    tve_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor(gap_reg), .done(div_done), .quotient(div_q));

    always_comb
    begin
        nidx = (head_reg[t] == '0) ? HW'(HISTORY_DEPTH - 1) : head_reg[t] - HW'(1);
        if ({1'b0, head_reg[t]} >= (HW+1)'(STEP + 1))
            ridx = head_reg[t] - HW'(STEP + 1);
        else
            ridx = HW'(32'(head_reg[t]) + HISTORY_DEPTH - STEP - 1);
        a_eff = (alpha_q8 == 9'd0) ? 9'd1 : (alpha_q8 > 9'd256 ? 9'd256 : alpha_q8);
    end

    always_comb
    begin
        case (dsel_reg)
            2'd0: dx33 = 33'($signed(nx_reg)) - 33'($signed(rx_reg));
            2'd1: dx33 = 33'($signed(ny_reg)) - 33'($signed(ry_reg));
            default:
            begin
                dw16 = na_reg - ra_reg;
                dx33 = 33'(dw16);
            end
        endcase
        if (dsel_reg != 2'd2)
            dw16 = '0;
        div_num = 58'(dx33) * $signed({1'b0, US_PER_S});
    end

    // EMA: a*inst + (256-a)*prev + 128, arithmetic shift is floor division by 256.
    logic signed [31:0] e_inst, e_prev;
    logic signed [42:0] e_sum;
    always_comb
    begin
        case (esel_reg)
            2'd0:    begin e_inst = ix_reg; e_prev = evx_mem[t]; end
            2'd1:    begin e_inst = iy_reg; e_prev = evy_mem[t]; end
            default: begin e_inst = iw_reg; e_prev = evw_mem[t]; end
        endcase
        e_sum = 43'(e_inst) * $signed({1'b0, a_eff}) +
            43'(e_prev) * $signed(10'(10'd256 - {1'b0, a_eff})) + 43'sd128;
        prod_prev = 32'(e_sum >>> 8);
    end

    logic do_store;
    assign do_store = (cnt_reg[t] == '0) ||
        (it_reg.sample_time >= lst_mem[t] &&
         (it_reg.sample_time - lst_mem[t]) >= {16'd0, min_interval});
    assign q_pop = st_reg == S_IDLE && q_valid;
    assign div_start = st_reg == S_DIV && dsel_reg[1:0] != 2'd3 && !comp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            out_valid <= 1'b0;
            lft_reg <= '0;
            ev_reg <= '0;
            seen_reg <= '0;
            comp_reg <= 1'b0;
            for (int k = 0; k < TRACKS; k++)
            begin
                cnt_reg[k] <= '0;
                head_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid && !out_stall && st_reg != S_OUT)
                out_valid <= 1'b0;
            case (st_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        it_reg <= q_data;
                        st_reg <= S_RD;
                    end
                S_RD:
                    if (it_reg.mode)
                    begin
                        for (int k = 0; k < TRACKS; k++)
                            if (!seen_reg[k])
                            begin
                                cnt_reg[k] <= '0;
                                head_reg[k] <= '0;
                                ev_reg[k] <= 1'b0;
                            end
                        seen_reg <= '0;
                        lft_reg <= it_reg.sample_time;
                        st_reg <= S_IDLE;
                    end
                    else if (32'(it_reg.track) >= TRACKS)
                        st_reg <= S_IDLE;
                    else if (it_reg.sample_time < lft_reg)
                    begin
                        for (int k = 0; k < TRACKS; k++)
                        begin
                            cnt_reg[k] <= '0;
                            head_reg[k] <= '0;
                        end
                        ev_reg <= '0;
                        lft_reg <= it_reg.sample_time;
                    end
                    else
                    begin
                        seen_reg[t] <= 1'b1;
                        ni_reg <= MAW'(32'(t) * HISTORY_DEPTH + 32'(nidx));
                        ri_reg <= MAW'(32'(t) * HISTORY_DEPTH + 32'(ridx));
                        comp_reg <= 1'b0;
                        st_reg <= S_CALC;
                    end
                S_CALC:
                begin
                    nx_reg <= hx_mem[ni_reg]; rx_reg <= hx_mem[ri_reg];
                    ny_reg <= hy_mem[ni_reg]; ry_reg <= hy_mem[ri_reg];
                    na_reg <= ha_mem[ni_reg]; ra_reg <= ha_mem[ri_reg];
                    ns_reg <= hs_mem[ni_reg]; rs_reg <= hs_mem[ri_reg];
                    comp_reg <= lft_reg != '0 && 32'(cnt_reg[t]) >= STEP + 1;
                    st_reg <= S_EMA;
                    esel_reg <= 2'd3;
                end
                S_EMA:
                    if (esel_reg == 2'd3)
                    begin
                        if (comp_reg && ns_reg > rs_reg)
                        begin
                            gap_reg <= ns_reg - rs_reg;
                            dsel_reg <= 2'd0;
                            comp_reg <= 1'b0;
                            st_reg <= S_DIV;
                        end
                        else
                        begin
                            comp_reg <= 1'b0;
                            ax_reg <= '0; ay_reg <= '0; aw_reg <= '0;
                            st_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        case (esel_reg)
                            2'd0: ax_reg <= ev_reg[t] ? prod_prev : ix_reg;
                            2'd1: ay_reg <= ev_reg[t] ? prod_prev : iy_reg;
                            default: aw_reg <= ev_reg[t] ? prod_prev : iw_reg;
                        endcase
                        if (esel_reg == 2'd2)
                        begin
                            comp_reg <= 1'b1;
                            st_reg <= S_OUT;
                        end
                        esel_reg <= esel_reg + 2'd1;
                    end
                S_DIV:
                begin
                    comp_reg <= !div_done;
                    if (div_done)
                    begin
                        case (dsel_reg)
                            2'd0: ix_reg <= div_q;
                            2'd1: iy_reg <= div_q;
                            default: iw_reg <= div_q;
                        endcase
                        if (dsel_reg == 2'd2)
                        begin
                            esel_reg <= 2'd0;
                            st_reg <= S_EMA;
                        end
                        dsel_reg <= dsel_reg + 2'd1;
                    end
                end
                S_OUT:
                    if (!out_valid || !out_stall)
                    begin
                        out_valid <= 1'b1;
                        out_track <= it_reg.track;
                        out_x <= it_reg.pos_x;
                        out_y <= it_reg.pos_y;
                        heading <= it_reg.yaw - QUARTER_TURN;
                        vel_x <= ax_reg;
                        vel_y <= ay_reg;
                        yaw_rate <= aw_reg;
                        vel_valid <= comp_reg;
                        if (comp_reg)
                            ev_reg[t] <= 1'b1;
                        if (do_store)
                        begin
                            head_reg[t] <= (32'(head_reg[t]) == HISTORY_DEPTH - 1) ?
                                '0 : head_reg[t] + HW'(1);
                            if (32'(cnt_reg[t]) < HISTORY_DEPTH)
                                cnt_reg[t] <= cnt_reg[t] + CW'(1);
                        end
                        comp_reg <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    logic [MAW-1:0] wa;
    assign wa = MAW'(32'(t) * HISTORY_DEPTH + 32'(head_reg[t]));
    always_ff @(posedge clk)
    begin
        if (st_reg == S_OUT && (!out_valid || !out_stall))
        begin
            if (comp_reg)
            begin
                evx_mem[t] <= ax_reg;
                evy_mem[t] <= ay_reg;
                evw_mem[t] <= aw_reg;
            end
            if (do_store)
            begin
                hx_mem[wa] <= it_reg.pos_x;
                hy_mem[wa] <= it_reg.pos_y;
                ha_mem[wa] <= it_reg.yaw;
                hs_mem[wa] <= it_reg.sample_time;
                lst_mem[t] <= it_reg.sample_time;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/tve_front.sv
// Front end: input transaction capture and configuration registers.
`default_nettype none
module tve_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire tve_pkg::item_t in_item,
    output logic                q_wr,
    input  wire logic           q_full,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic [8:0]          alpha_q8,
    output logic [23:0]         min_interval
);
    import tve_pkg::*;
    logic [8:0] alpha_reg;
    logic [23:0] int_reg;

    assign in_stall = q_full;
    assign q_wr = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            int_reg <= INTERVAL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case ({1'b0, paddr[2]})
                ADDR_ALPHA:    alpha_reg <= pwdata[8:0];
                ADDR_INTERVAL: int_reg <= pwdata[23:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case ({1'b0, paddr[2]})
            ADDR_ALPHA:    prdata = {23'd0, alpha_reg};
            ADDR_INTERVAL: prdata = {8'd0, int_reg};
            default:       prdata = 32'd0;
        endcase
    end
    assign alpha_q8 = alpha_reg;
    assign min_interval = int_reg;
endmodule
`default_nettype wire

// File: rtl/track_velocity_estimator_top.sv
// Top level of the per-track velocity estimator.
`default_nettype none
// One detection transaction yields one report, except that a detection whose track
// number is not below TRACKS gives none. When a velocity is computed, three signed
// divisions by the time gap run in turn on one shared bit-serial divider. A
// detection with too little history or no usable time gap skips the divisions and
// reports with zero velocity; a detection that runs backwards in time first clears
// the history of every track. End-of-frame items give no report. A stalled report
// holds the back end, and a two-entry queue decouples input from processing.
module track_velocity_estimator_top
#(
    parameter int TRACKS = 16,
    parameter int HISTORY_DEPTH = 5,
    parameter int STEP = 3
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic [3:0]         track,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [15:0] yaw,
    input  wire logic [39:0]        sample_time,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              out_track,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [15:0]      heading,
    output logic signed [31:0]      vel_x,
    output logic signed [31:0]      vel_y,
    output logic signed [31:0]      yaw_rate,
    output logic                    vel_valid,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import tve_pkg::*;
    item_t in_item, q_data;
    logic q_wr, q_full, q_ne, q_pop;
    logic [8:0] alpha;
    logic [23:0] interval;

    assign in_item = '{mode: mode, track: track, pos_x: pos_x, pos_y: pos_y, yaw: yaw,
        sample_time: sample_time};
    assign pready = 1'b1;

    tve_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_wr(q_wr), .q_full(q_full), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .alpha_q8(alpha), .min_interval(interval));

    tve_queue u_queue (.clk(clk), .rst_n(rst_n), .wr_en(q_wr), .wr_data(in_item),
        .full(q_full), .not_empty(q_ne), .rd_data(q_data), .rd_en(q_pop));

    tve_back #(.TRACKS(TRACKS), .HISTORY_DEPTH(HISTORY_DEPTH), .STEP(STEP)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_data(q_data), .q_pop(q_pop),
        .alpha_q8(alpha), .min_interval(interval), .out_valid(out_valid),
        .out_stall(out_stall), .out_track(out_track), .out_x(out_x), .out_y(out_y),
        .heading(heading), .vel_x(vel_x), .vel_y(vel_y), .yaw_rate(yaw_rate),
        .vel_valid(vel_valid));
endmodule
`default_nettype wire

// File: rtl/tve_checker.sv
// Port-level checker for the velocity estimator and its bind statement.
`default_nettype none
module tve_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] vel_x,
    input wire logic [31:0] vel_y,
    input wire logic [31:0] yaw_rate,
    input wire logic        vel_valid,
    input wire logic        pready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("report dropped");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !vel_valid |-> vel_x == 0 && vel_y == 0 && yaw_rate == 0)
        else $error("velocity without valid");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind track_velocity_estimator_top tve_checker u_chk (.clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_stall(out_stall), .vel_x(vel_x), .vel_y(vel_y),
    .yaw_rate(yaw_rate), .vel_valid(vel_valid), .pready(pready));
`default_nettype wire
